// ===== hw/rtl/lcddr_pkg.sv =====
package lcddr_pkg;

   localparam logic [7:0] CHAR_BLANK     = 8'h20;
   localparam logic [7:0] CHAR_UNTRUSTED = 8'hFF;
   localparam logic [7:0] EXP_BACKLIGHT  = 8'h08;
   localparam logic [7:0] EXP_ENABLE     = 8'h04;
   localparam logic [7:0] EXP_SELECT     = 8'h01;

   localparam int         CSR_ADDR_W    = 3;
   localparam logic       REG_BACKLIGHT = 1'b0;

   typedef enum logic [2:0] {
      OP_WRITE_CHAR   = 3'd0,
      OP_BLANK_WANTED = 3'd1,
      OP_FLUSH        = 3'd2,
      OP_INVALIDATE   = 3'd3,
      OP_BLANK_BOTH   = 3'd4
   } lcddr_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_FINAL
   } lcddr_state_type;

   typedef struct packed {
      logic        has_transaction;
      logic        is_data;
      logic [7:0]  byte_value;
      logic [31:0] expander_word;
      logic        last_of_flush;
   } lcddr_result_type;

   // Four expander bytes that clock one LCD byte in as two nibbles.
   function automatic logic [31:0] lcddr_expand(logic [7:0] value, logic select,
                                                 logic backlight);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = {value[7:4], 4'h0} | (backlight ? EXP_BACKLIGHT : 8'h00)
           | (select ? EXP_SELECT : 8'h00);
      lo = {value[3:0], 4'h0} | (backlight ? EXP_BACKLIGHT : 8'h00)
           | (select ? EXP_SELECT : 8'h00);
      return {hi | EXP_ENABLE, hi, lo | EXP_ENABLE, lo};
   endfunction

endpackage

// ===== hw/rtl/lcddr_req_if.sv =====
interface lcddr_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic       row_index;
   logic [3:0] column_index;
   logic [7:0] char_code;

   modport source (output valid, output opcode, output row_index, output column_index,
                   output char_code, input ready);
   modport sink (input valid, input opcode, input row_index, input column_index,
                 input char_code, output ready);
endinterface

// ===== hw/rtl/lcddr_rsp_if.sv =====
interface lcddr_rsp_if;
   logic        valid;
   logic        ready;
   logic        has_transaction;
   logic        is_data;
   logic [7:0]  byte_value;
   logic [31:0] expander_word;
   logic        last_of_flush;

   modport source (output valid, output has_transaction, output is_data,
                   output byte_value, output expander_word, output last_of_flush,
                   input ready);
   modport sink (input valid, input has_transaction, input is_data,
                 input byte_value, input expander_word, input last_of_flush,
                 output ready);
endinterface

// ===== hw/rtl/lcddr_store.sv =====
module lcddr_store #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic [7:0]    fill_value,
   output logic [7:0]    rd_data
);

   logic [7:0]       mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [7:0]       rd_word_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff  <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : fill_value;

endmodule

// ===== hw/rtl/lcddr_scan.sv =====
module lcddr_scan import lcddr_pkg::*; #(
   parameter int ROWS    = 2,
   parameter int COLUMNS = 16,
   parameter int AW      = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              backlight,
   output logic              idle,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr,
   input  logic [7:0]        wanted_data,
   input  logic [7:0]        shown_data,
   output logic              shown_wr_en,
   output logic [7:0]        shown_wr_data,
   lcddr_rsp_if.source       rsp_port
);

   localparam int CW = $clog2(COLUMNS);

   lcddr_state_type  state_ff, state_in;
   logic [AW-1:0]    cell_ff, cell_in;
   logic [CW-1:0]    col_ff, col_in;
   logic             row_ff, row_in;
   logic             in_run_ff, in_run_in;
   lcddr_result_type hold_ff, hold_in;
   logic             hold_valid_ff, hold_valid_in;
   lcddr_result_type out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   logic             differ;
   logic             out_free;
   logic             can_push;
   logic             push;
   logic             advance;
   logic             final_load;
   logic             out_load;
   logic [7:0]       cmd_byte;
   lcddr_result_type push_res;
   lcddr_result_type cmd_res;
   lcddr_result_type data_res;
   lcddr_result_type empty_res;

   assign differ   = wanted_data != shown_data;
   assign out_free = !out_valid_ff || rsp_port.ready;
   assign can_push = !hold_valid_ff || out_free;
   assign cmd_byte = {1'b1, row_ff, 6'(col_ff)};

   always_comb begin
      cmd_res                  = '0;
      cmd_res.has_transaction  = 1'b1;
      cmd_res.byte_value       = cmd_byte;
      cmd_res.expander_word    = lcddr_expand(cmd_byte, 1'b0, backlight);
      data_res                 = '0;
      data_res.has_transaction = 1'b1;
      data_res.is_data         = 1'b1;
      data_res.byte_value      = wanted_data;
      data_res.expander_word   = lcddr_expand(wanted_data, 1'b1, backlight);
      empty_res                = '0;
      empty_res.last_of_flush  = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff   <= cell_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      in_run_ff <= in_run_in;
      hold_ff   <= hold_in;
      out_ff    <= out_in;
   end

   always_comb begin
      state_in    = state_ff;
      cell_in     = cell_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      in_run_in   = in_run_ff;
      rd_en       = 1'b0;
      push        = 1'b0;
      push_res    = cmd_res;
      advance     = 1'b0;
      shown_wr_en = 1'b0;
      final_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cell_in   = '0;
               col_in    = '0;
               row_in    = 1'b0;
               in_run_in = 1'b0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (differ) begin
               if (!in_run_ff) begin
                  if (can_push) begin
                     push      = 1'b1;
                     push_res  = cmd_res;
                     in_run_in = 1'b1;
                  end
               end else if (can_push) begin
                  push        = 1'b1;
                  push_res    = data_res;
                  shown_wr_en = 1'b1;
                  advance     = 1'b1;
               end
            end else begin
               in_run_in = 1'b0;
               advance   = 1'b1;
            end
            if (advance) begin
               cell_in = cell_ff + 1'b1;
               if (col_ff == CW'(COLUMNS - 1)) begin
                  col_in    = '0;
                  in_run_in = 1'b0;
                  if (row_ff == 1'(ROWS - 1)) begin
                     state_in = ST_FINAL;
                  end else begin
                     row_in   = row_ff + 1'b1;
                     state_in = ST_READ;
                  end
               end else begin
                  col_in   = col_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               final_load = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The newest result waits in the hold stage until the next one shows that it is not the last.
   always_comb begin
      out_load      = (push && hold_valid_ff) || final_load;
      hold_in       = push ? push_res : hold_ff;
      hold_valid_in = push ? 1'b1 : (final_load ? 1'b0 : hold_valid_ff);
      out_in        = out_ff;
      if (final_load) begin
         if (hold_valid_ff) begin
            out_in               = hold_ff;
            out_in.last_of_flush = 1'b1;
         end else begin
            out_in = empty_res;
         end
      end else if (out_load) begin
         out_in = hold_ff;
      end
      out_valid_in = out_load ? 1'b1 : (rsp_port.ready ? 1'b0 : out_valid_ff);
   end

   assign idle          = state_ff == ST_IDLE;
   assign rd_addr       = cell_ff;
   assign shown_wr_data = wanted_data;

   assign rsp_port.valid           = out_valid_ff;
   assign rsp_port.has_transaction = out_ff.has_transaction;
   assign rsp_port.is_data         = out_ff.is_data;
   assign rsp_port.byte_value      = out_ff.byte_value;
   assign rsp_port.expander_word   = out_ff.expander_word;
   assign rsp_port.last_of_flush   = out_ff.last_of_flush;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ST_IDLE)
      else $error("flush started while a scan is running");

   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hold_valid_ff)
      else $error("held word left behind after a flush");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> col_ff <= CW'(COLUMNS - 1))
      else $error("column counter out of range");

   a_final_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL && out_free) |=>
         (state_ff == ST_IDLE && out_valid_ff && out_ff.last_of_flush))
      else $error("flush did not end with a last word");

   a_shown_write: assert property (@(posedge clock) disable iff (reset)
      shown_wr_en |-> (in_run_ff && state_ff == ST_CMP && differ))
      else $error("shown screen written outside a run");

endmodule

// ===== hw/rtl/char_lcd_diff_refresh.sv =====
// Differential refresh for a two-row character LCD driven through a 4-bit port expander.
// The req channel carries one operation per word: write a character into the wanted screen,
// blank the wanted screen, blank both screens, mark the shown screen untrusted, or flush.
// Every operation but flush completes in the cycle it is accepted and the block is ready
// again on the next cycle. A flush scans all ROWS*COLUMNS cells through one compare unit:
// each cell is read (ST_READ) and then compared (ST_CMP), and a cell that opens a run of
// differing cells stays in ST_CMP to send the set-address command before its data byte;
// ST_FINAL closes the flush. Both screens are read at one shared address, a cell at a time.
// The flush sends its words on the rsp channel: one set-address command per run of
// differing cells followed by its data bytes, each with the four expander bytes that clock
// it in. The last word of a flush carries last_of_flush; a flush with nothing to send gives
// one empty word. Results leave one word behind the scan, through a hold stage and an output
// register, so a word reaches rsp only once the scan has found the next one or has finished.
// If the receiver stalls, the scan pauses on the next word it has to send and req stays not
// ready until the flush ends. Reset marks both screens as at power-up (wanted blank, shown
// untrusted) through per-cell valid bits and sets the backlight bit.
// The backlight register is written over the APB port at addresses 0 to 3 (paddr bit 2 low).
module char_lcd_diff_refresh import lcddr_pkg::*; #(
   parameter int ROWS    = 2,
   parameter int COLUMNS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   lcddr_req_if.sink             req_port,
   lcddr_rsp_if.source           rsp_port,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);

   logic          backlight_ff, backlight_in;
   logic [7:0]    shown_fill_ff, shown_fill_in;
   logic          csr_write;
   logic          csr_index;

   logic          accept;
   logic          scan_idle;
   logic          flush_start;
   logic          wanted_wr_en;
   logic [AW-1:0] wanted_wr_addr;
   logic          wanted_clear;
   logic          shown_clear;
   logic          in_range;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    wanted_data;
   logic [7:0]    shown_data;
   logic          shown_wr_en;
   logic [7:0]    shown_wr_data;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_index == REG_BACKLIGHT) ? {31'b0, backlight_ff} : 32'b0;

   assign accept         = req_port.valid && req_port.ready;
   assign req_port.ready = scan_idle;
   assign in_range       = (req_port.row_index == 1'b0 || ROWS > 1)
                           && (32'(req_port.column_index) < COLUMNS);
   assign wanted_wr_addr = req_port.row_index ? AW'(COLUMNS) + AW'(req_port.column_index)
                                              : AW'(req_port.column_index);

   always_comb begin
      flush_start   = 1'b0;
      wanted_wr_en  = 1'b0;
      wanted_clear  = 1'b0;
      shown_clear   = 1'b0;
      shown_fill_in = shown_fill_ff;
      backlight_in  = backlight_ff;
      if (csr_write && csr_index == REG_BACKLIGHT) begin
         backlight_in = csr_pwdata[0];
      end
      if (accept) begin
         case (req_port.opcode)
            OP_WRITE_CHAR: begin
               wanted_wr_en = in_range;
            end
            OP_BLANK_WANTED: begin
               wanted_clear = 1'b1;
            end
            OP_FLUSH: begin
               flush_start = 1'b1;
            end
            OP_INVALIDATE: begin
               shown_clear   = 1'b1;
               shown_fill_in = CHAR_UNTRUSTED;
            end
            OP_BLANK_BOTH: begin
               wanted_clear  = 1'b1;
               shown_clear   = 1'b1;
               shown_fill_in = CHAR_BLANK;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         backlight_ff  <= 1'b1;
         shown_fill_ff <= CHAR_UNTRUSTED;
      end else begin
         backlight_ff  <= backlight_in;
         shown_fill_ff <= shown_fill_in;
      end
   end

   lcddr_store #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_wanted (
      .clock      (clock),
      .reset      (reset),
      .clear      (wanted_clear),
      .wr_en      (wanted_wr_en),
      .wr_addr    (wanted_wr_addr),
      .wr_data    (req_port.char_code),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .fill_value (CHAR_BLANK),
      .rd_data    (wanted_data)
   );

   lcddr_store #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_shown (
      .clock      (clock),
      .reset      (reset),
      .clear      (shown_clear),
      .wr_en      (shown_wr_en),
      .wr_addr    (rd_addr),
      .wr_data    (shown_wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .fill_value (shown_fill_ff),
      .rd_data    (shown_data)
   );

   lcddr_scan #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS),
      .AW      (AW)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .start         (flush_start),
      .backlight     (backlight_ff),
      .idle          (scan_idle),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .wanted_data   (wanted_data),
      .shown_data    (shown_data),
      .shown_wr_en   (shown_wr_en),
      .shown_wr_data (shown_wr_data),
      .rsp_port      (rsp_port)
   );

endmodule
